/* rtl/aligned_stack_allocator_assert.svh */
// Assertion helpers for the stack allocator.
// Both expect signals named clock and reset in the using scope.
`ifndef ALIGNED_STACK_ALLOCATOR_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define ASA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: assertion failed");

`define ASA_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("%m: forbidden condition");

`else

`define ASA_ASSERT(lbl, prop)

`define ASA_NEVER(lbl, expr)

`endif

`endif

/* rtl/asa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package asa_pkg;

   localparam int HEADER_BYTES_DEF = 8;
   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int ADDR_BITS_DEF    = 32;

   localparam int DATA_W   = 32;
   localparam int ALIGN_W  = 4;
   localparam int PAD_W    = 13;
   localparam int STATUS_W = 3;
   localparam int LIVE_W   = 7;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 56;

   localparam logic [ALIGN_W-1:0] ALIGN_LOG2_MAX = 4'd12;
   localparam logic [DATA_W-1:0]  POOL_BYTES_RST = 32'd65536;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BYTES = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_OOM     = 3'd1,
      ST_INVALID = 3'd2,
      ST_ORDER   = 3'd3,
      ST_EMPTY   = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/asa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "aligned_stack_allocator_assert.svh"

module asa_ctrl (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire             rsp_tready,
   output asa_pkg::cmd_type cmd
);

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      cmd.capture   = (state_ff == IDLE) && req_tvalid;
      cmd.execute   = (state_ff == EXEC) && (!rsp_tvalid_ff || rsp_tready);
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               state_in = EXEC;
            end
         end
         EXEC: begin
            if (cmd.execute) begin
               state_in      = IDLE;
               rsp_tvalid_in = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // one request in flight at a time
   `ASA_ASSERT(a_one_in_flight, (req_tvalid && req_tready) |=> !req_tready)
   // a waiting response is never overwritten
   `ASA_NEVER(a_no_overwrite, cmd.execute && rsp_tvalid_ff && !rsp_tready)
   `ASA_ASSERT(a_exec_gives_rsp, cmd.execute |=> rsp_tvalid)

endmodule

`default_nettype wire

/* rtl/asa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "aligned_stack_allocator_assert.svh"

module asa_dp #(
   parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = asa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS    = asa_pkg::ADDR_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  asa_pkg::cmd_type                 cmd,
   input  wire                              csr_we,
   input  wire [asa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [asa_pkg::DATA_W-1:0]        csr_wdata,
   input  wire                              op,
   input  wire [asa_pkg::DATA_W-1:0]        request_bytes,
   input  wire [asa_pkg::ALIGN_W-1:0]       align_log2,
   input  wire [asa_pkg::DATA_W-1:0]        release_address,
   output logic [asa_pkg::DATA_W-1:0]       block_address,
   output logic [asa_pkg::PAD_W-1:0]        padding,
   output asa_pkg::status_type              status,
   output logic [asa_pkg::LIVE_W-1:0]       live_blocks
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int XW = (ADDR_BITS > asa_pkg::DATA_W) ? ADDR_BITS : asa_pkg::DATA_W;
   localparam int PW = asa_pkg::PAD_W + 1;
   localparam int MW = asa_pkg::PAD_W + ADDR_BITS;
   localparam int SW = asa_pkg::DATA_W + 2;
   localparam logic [PW-1:0] HDR = PW'(HEADER_BYTES);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

   // configuration
   logic [asa_pkg::DATA_W-1:0] pool_base_ff, pool_bytes_ff;

   // allocator state
   logic [asa_pkg::DATA_W-1:0] top_offset_ff, top_offset_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [MW-1:0]              stack_mem [MAX_BLOCKS];

   // captured request
   logic                       op_ff;
   logic [asa_pkg::DATA_W-1:0] req_bytes_ff, rel_ff;
   logic [asa_pkg::ALIGN_W-1:0] align_ff;
   logic [ADDR_BITS-1:0]       top_addr_ff;
   logic [asa_pkg::DATA_W:0]   top_req_ff;
   logic [MW-1:0]              rd_data_ff;

   // results
   logic [asa_pkg::DATA_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [asa_pkg::PAD_W-1:0]  rsp_pad_ff, rsp_pad_in;
   asa_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [asa_pkg::LIVE_W-1:0] rsp_live_ff;

   logic [XW-1:0]        top_sum;
   logic [CW-1:0]        count_dec;
   logic [IW-1:0]        rd_idx, wr_idx;
   logic                 wr_en;
   logic [PW-1:0]        mask, adj, gap, rounded, pad;
   logic [SW-1:0]        end_sum;
   logic [ADDR_BITS-1:0] aligned, rel_a, stk_addr, restored;
   logic [XW-1:0]        aligned_x, rel_x, restored_x;
   logic [asa_pkg::PAD_W-1:0] stk_pad;
   logic                 invalid, full, oom, empty, order;

   always_comb begin
      top_sum   = XW'(pool_base_ff) + XW'(top_offset_ff);
      count_dec = count_ff - 1'b1;
      rd_idx    = count_dec[IW-1:0];
      wr_idx    = count_ff[IW-1:0];
   end

   // allocate path
   always_comb begin
      mask    = (PW'(1) << align_ff) - 1'b1;
      adj     = (~top_addr_ff[PW-1:0] + 1'b1) & mask;
      gap     = HDR - adj;
      rounded = ((gap + mask) >> align_ff) << align_ff;
      pad     = (adj < HDR) ? (adj + rounded) : adj;
      end_sum = SW'(top_req_ff) + SW'(pad);
      aligned = top_addr_ff + ADDR_BITS'(pad);
      aligned_x = XW'(aligned);
      invalid = (req_bytes_ff == '0) || (align_ff > asa_pkg::ALIGN_LOG2_MAX);
      full    = (count_ff >= MAX_CNT);
      oom     = (end_sum > SW'(pool_bytes_ff));
   end

   // release path
   always_comb begin
      rel_x      = XW'(rel_ff);
      rel_a      = rel_x[ADDR_BITS-1:0];
      stk_addr   = rd_data_ff[ADDR_BITS-1:0];
      stk_pad    = rd_data_ff[MW-1 -: asa_pkg::PAD_W];
      restored   = rel_a - ADDR_BITS'(stk_pad);
      restored_x = XW'(restored);
      empty      = (count_ff == '0);
      order      = (stk_addr != rel_a);
   end

   always_comb begin
      rsp_addr_in   = '0;
      rsp_pad_in    = '0;
      rsp_status_in = asa_pkg::ST_OK;
      top_offset_in = top_offset_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      if (op_ff == asa_pkg::OP_ALLOC) begin
         if (invalid) begin
            rsp_status_in = asa_pkg::ST_INVALID;
         end else if (full) begin
            rsp_status_in = asa_pkg::ST_FULL;
         end else if (oom) begin
            rsp_status_in = asa_pkg::ST_OOM;
         end else begin
            rsp_addr_in   = aligned_x[asa_pkg::DATA_W-1:0];
            rsp_pad_in    = pad[asa_pkg::PAD_W-1:0];
            top_offset_in = end_sum[asa_pkg::DATA_W-1:0];
            count_in      = count_ff + 1'b1;
            wr_en         = 1'b1;
         end
      end else begin
         if (empty) begin
            rsp_status_in = asa_pkg::ST_EMPTY;
         end else if (order) begin
            rsp_status_in = asa_pkg::ST_ORDER;
         end else begin
            rsp_addr_in   = restored_x[asa_pkg::DATA_W-1:0];
            rsp_pad_in    = stk_pad;
            top_offset_in = restored_x[asa_pkg::DATA_W-1:0] - pool_base_ff;
            count_in      = count_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_bytes_ff <= asa_pkg::POOL_BYTES_RST;
         top_offset_ff <= '0;
         count_ff      <= '0;
         rsp_addr_ff   <= '0;
         rsp_pad_ff    <= '0;
         rsp_status_ff <= asa_pkg::ST_OK;
         rsp_live_ff   <= '0;
      end else begin
         if (csr_we && (csr_index == asa_pkg::CSR_POOL_BASE)) begin
            pool_base_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == asa_pkg::CSR_POOL_BYTES)) begin
            pool_bytes_ff <= csr_wdata;
         end
         if (cmd.execute) begin
            top_offset_ff <= top_offset_in;
            count_ff      <= count_in;
            rsp_addr_ff   <= rsp_addr_in;
            rsp_pad_ff    <= rsp_pad_in;
            rsp_status_ff <= rsp_status_in;
            rsp_live_ff   <= asa_pkg::LIVE_W'(count_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= op;
         req_bytes_ff <= request_bytes;
         align_ff     <= align_log2;
         rel_ff       <= release_address;
         top_addr_ff  <= top_sum[ADDR_BITS-1:0];
         top_req_ff   <= (asa_pkg::DATA_W + 1)'(top_offset_ff) +
                         (asa_pkg::DATA_W + 1)'(request_bytes);
         rd_data_ff   <= stack_mem[rd_idx];
      end
      if (cmd.execute && wr_en) begin
         stack_mem[wr_idx] <= {pad[asa_pkg::PAD_W-1:0], aligned};
      end
   end

   assign block_address = rsp_addr_ff;
   assign padding       = rsp_pad_ff;
   assign status        = rsp_status_ff;
   assign live_blocks   = rsp_live_ff;

   `ASA_ASSERT(a_count_bound, count_ff <= MAX_CNT)
   `ASA_ASSERT(a_alloc_push, (cmd.execute && (op_ff == asa_pkg::OP_ALLOC) && (rsp_status_in == asa_pkg::ST_OK)) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
   `ASA_ASSERT(a_err_zero, (rsp_status_ff != asa_pkg::ST_OK) |-> ((rsp_addr_ff == '0) && (rsp_pad_ff == '0)))
   `ASA_ASSERT(a_err_keeps_top, (cmd.execute && (rsp_status_in != asa_pkg::ST_OK)) |=> ($stable(top_offset_ff) && $stable(count_ff)))

endmodule

`default_nettype wire

/* rtl/aligned_stack_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// LIFO allocator over the pool [pool_base, pool_base + pool_bytes). Each request has a
// capture step, which takes the operands and reads the top entry of the allocation stack
// memory, and a commit step, which computes padding, bounds and order checks and commits
// the new top. A request is taken whenever the controller is idle, also while the
// previous response still waits; the response register holds until rsp_tready, which
// stalls the commit step. No clearing pass after reset. Write pool_base and pool_bytes
// only while no request is outstanding.
module aligned_stack_allocator #(
   parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES_DEF,
   parameter int MAX_BLOCKS   = asa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS    = asa_pkg::ADDR_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire [asa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [asa_pkg::DATA_W-1:0]         csr_wdata,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // request_bytes[31:0], align_log2[35:32], release_address[67:36]
   input  wire [asa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // op[0]
   input  wire [0:0]                         req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // block_address[31:0], padding[44:32], live_blocks[51:45]
   output logic [asa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status[2:0]
   output logic [asa_pkg::STATUS_W-1:0]      rsp_tuser
);

   asa_pkg::cmd_type                 cmd;
   logic [asa_pkg::DATA_W-1:0]       block_address;
   logic [asa_pkg::PAD_W-1:0]        padding;
   asa_pkg::status_type              status;
   logic [asa_pkg::LIVE_W-1:0]       live_blocks;

   asa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   asa_dp #(
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .op              (req_tuser[0]),
      .request_bytes   (req_tdata[31:0]),
      .align_log2      (req_tdata[35:32]),
      .release_address (req_tdata[67:36]),
      .block_address   (block_address),
      .padding         (padding),
      .status          (status),
      .live_blocks     (live_blocks)
   );

   assign rsp_tdata = {4'b0000, live_blocks, padding, block_address};
   assign rsp_tuser = status;

endmodule

`default_nettype wire

/* bench/aligned_stack_allocator_checker.sv */
`timescale 1ns / 1ps

module aligned_stack_allocator_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [asa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [asa_pkg::DATA_W-1:0]        csr_wdata,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   // request_bytes[31:0], align_log2[35:32], release_address[67:36]
   input  wire [asa_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op[0]
   input  wire [0:0]                        req_tuser,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   // block_address[31:0], padding[44:32], live_blocks[51:45]
   input  wire [asa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status[2:0]
   input  wire [asa_pkg::STATUS_W-1:0]      rsp_tuser,
   output int                               errors,
   output int                               pending,
   output int                               live_now,
   output logic [asa_pkg::DATA_W-1:0]       latest_block
);
   import asa_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] address;
      logic [PAD_W-1:0]  padding;
      status_type        status;
      logic [LIVE_W-1:0] live;
   } grant_t;

   grant_t            grant_q[$];
   logic [DATA_W-1:0] pool_base;
   logic [DATA_W-1:0] pool_size;
   logic [DATA_W-1:0] top_offset;
   int                block_count;
   logic [PAD_W-1:0]  pad_stack[MAX_BLOCKS_DEF];
   logic [DATA_W-1:0] addr_stack[MAX_BLOCKS_DEF];

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
         input logic [DATA_W-1:0] want);
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic grant_t predict_grant(input logic op, input logic [DATA_W-1:0] nbytes,
         input logic [ALIGN_W-1:0] alog, input logic [DATA_W-1:0] rel);
      grant_t            g;
      logic [DATA_W-1:0] top_addr;
      logic [DATA_W-1:0] align;
      logic [DATA_W-1:0] pad;
      logic [63:0]       fin;
      g = '{address: '0, padding: '0, status: ST_OK, live: '0};
      if (op == OP_ALLOC) begin
         if (nbytes == 0 || alog > ALIGN_LOG2_MAX) begin
            g.status = ST_INVALID;
         end else if (block_count >= MAX_BLOCKS_DEF) begin
            g.status = ST_FULL;
         end else begin
            top_addr = pool_base + top_offset;
            align = 32'd1 << alog;
            pad = (32'd0 - top_addr) & (align - 32'd1);
            // header room: bump by whole alignment steps until it fits
            if (pad < HEADER_BYTES_DEF) begin
               pad += align * ((HEADER_BYTES_DEF - pad - 1) / align + 1);
            end
            fin = 64'(top_offset) + 64'(pad) + 64'(nbytes);
            if (fin > 64'(pool_size)) begin
               g.status = ST_OOM;
            end else begin
               g.address = top_addr + pad;
               g.padding = pad[PAD_W-1:0];
               pad_stack[block_count] = pad[PAD_W-1:0];
               addr_stack[block_count] = g.address;
               block_count++;
               top_offset = fin[DATA_W-1:0];
            end
         end
      end else if (block_count == 0) begin
         g.status = ST_EMPTY;
      end else if (addr_stack[block_count-1] != rel) begin
         g.status = ST_ORDER;
      end else begin
         g.padding = pad_stack[block_count-1];
         g.address = rel - 32'(pad_stack[block_count-1]);
         top_offset = g.address - pool_base;
         block_count--;
      end
      g.live = LIVE_W'(block_count);
      return g;
   endfunction

   always @(posedge clock) begin
      grant_t want;
      grant_t got;
      if (reset) begin
         pool_base = '0;
         pool_size = POOL_BYTES_RST;
         top_offset = '0;
         block_count = 0;
         grant_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{address: rsp_tdata[31:0], padding: rsp_tdata[44:32],
                    status: status_type'(rsp_tuser), live: rsp_tdata[51:45]};
            if (grant_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[31:0], '0);
            end else begin
               want = grant_q.pop_front();
               if (got.address !== want.address)
                  report_mismatch("block_address", got.address, want.address);
               if (got.padding !== want.padding)
                  report_mismatch("padding", 32'(got.padding), 32'(want.padding));
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (got.live !== want.live)
                  report_mismatch("live_blocks", 32'(got.live), 32'(want.live));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_POOL_BASE: begin
                  pool_base = csr_wdata;
               end
               CSR_POOL_BYTES: begin
                  pool_size = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            grant_q.push_back(predict_grant(req_tuser[0], req_tdata[31:0], req_tdata[35:32],
                                            req_tdata[67:36]));
         end
      end
      pending <= grant_q.size();
      live_now <= block_count;
      latest_block <= (block_count > 0) ? addr_stack[block_count-1] : '0;
   end

endmodule

/* bench/aligned_stack_allocator_tb.sv */
`timescale 1ns / 1ps

module aligned_stack_allocator_tb;
   import asa_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef enum {REL_GIVEN, REL_LATEST, REL_BROKEN} rel_kind_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [DATA_W-1:0]          csr_wdata;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_W-1:0]     req_tdata;
   logic [0:0]                 req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0]        rsp_tuser;

   int                         errors;
   int                         pending;
   int                         live_now;
   logic [DATA_W-1:0]          latest_block;
   int                         depth_guess = 0;
   int                         calm_left = 0;
   int                         quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   aligned_stack_allocator dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   aligned_stack_allocator_checker checker_i (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .errors(errors), .pending(pending), .live_now(live_now), .latest_block(latest_block)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(1, 64);
      if (r < 80) return $urandom_range(65, 1024);
      if (r < 92) return $urandom_range(1025, 65536);
      if (r < 97) return $urandom;
      return '0;
   endfunction

   function automatic logic [ALIGN_W-1:0] pick_align();
      if ($urandom_range(0, 99) < 95) return ALIGN_W'($urandom_range(0, 12));
      return ALIGN_W'($urandom_range(13, 15));
   endfunction

   // release addresses taken from the predicted stack are read at the falling edge
   task automatic issue(input logic op, input logic [DATA_W-1:0] nbytes,
         input logic [ALIGN_W-1:0] alog, input logic [DATA_W-1:0] rel,
         input rel_kind_type how);
      int                gap;
      logic [DATA_W-1:0] addr;
      addr = rel;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 80);
      end
      if (gap != 0 || how != REL_GIVEN) req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
      if (how != REL_GIVEN) begin
         @(negedge clock);
         depth_guess = live_now;
         addr = latest_block;
         if (how == REL_BROKEN) addr ^= 32'd1 << $urandom_range(0, 31);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0, addr, alog, nbytes};
      do @(posedge clock); while (!req_tready);
      if (op == OP_ALLOC) begin
         if (depth_guess < MAX_BLOCKS_DEF) depth_guess++;
      end else if (depth_guess > 0) begin
         depth_guess--;
      end
   endtask

   task automatic allocate(input logic [DATA_W-1:0] nbytes, input logic [ALIGN_W-1:0] alog);
      issue(OP_ALLOC, nbytes, alog, $urandom, REL_GIVEN);
   endtask

   task automatic free_block(input rel_kind_type how, input logic [DATA_W-1:0] rel = '0);
      issue(OP_RELEASE, $urandom, ALIGN_W'($urandom_range(0, 15)), rel, how);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_run(input int n);
      int r;
      int target;
      target = 0;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            r = $urandom_range(0, 9);
            if (r < 3) target = $urandom_range(0, 4);
            else if (r < 7) target = $urandom_range(5, 30);
            else target = $urandom_range(60, 70);
         end
         if ($urandom_range(0, 99) == 0) drain();
         r = $urandom_range(0, 99);
         if (r < 8) begin
            issue(1'($urandom_range(0, 1)), $urandom, ALIGN_W'($urandom_range(0, 15)),
                  $urandom, REL_GIVEN);
         end else if (depth_guess < target) begin
            allocate(pick_size(), pick_align());
         end else if (r < 90) begin
            free_block(REL_LATEST);
         end else if (r < 96) begin
            free_block(REL_BROKEN);
         end else begin
            free_block(REL_GIVEN, $urandom);
         end
      end
   endtask

   initial begin
      int run;
      int gap;
      rsp_tready <= 1'b0;
      forever begin
         run = $urandom_range(1, 40);
         if ($urandom_range(0, 9) == 0) run = $urandom_range(100, 400);
         repeat (run) begin
            @(posedge clock);
            rsp_tready <= 1'b1;
         end
         gap = pick_gap();
         repeat (gap) begin
            @(posedge clock);
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_POOL_BASE;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_ALLOC;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: base 0, 64 KiB
      free_block(REL_LATEST);
      allocate(32'd0, 4'd3);
      allocate(32'd16, 4'd13);
      allocate(32'hFFFF_FFFF, 4'd15);
      allocate(32'd1, 4'd0);
      allocate(32'd100, ALIGN_LOG2_MAX);
      allocate(32'hFFFF_FFFF, 4'd0);
      allocate(32'd24, 4'd3);
      free_block(REL_BROKEN);
      free_block(REL_GIVEN, 32'hFFFF_FFFF);
      free_block(REL_LATEST);
      free_block(REL_LATEST);
      free_block(REL_LATEST);
      free_block(REL_LATEST);

      // exact fill: header plus 100 bytes
      drain();
      write_reg(CSR_POOL_BYTES, 32'd108);
      allocate(32'd100, 4'd0);
      allocate(32'd1, 4'd0);
      free_block(REL_LATEST);
      allocate(32'd101, 4'd0);
      allocate(32'd100, 4'd3);
      free_block(REL_LATEST);
      drain();
      write_reg(CSR_POOL_BYTES, POOL_BYTES_RST);
      random_run(400);

      // region wraps past the top of the address space
      drain();
      write_reg(CSR_POOL_BASE, 32'hFFFF_FF00);
      write_reg(CSR_POOL_BYTES, 32'hFFFF_FFFF);
      random_run(350);

      // tiny regions, down to a single byte
      drain();
      write_reg(CSR_POOL_BASE, $urandom);
      write_reg(CSR_POOL_BYTES, 32'd1);
      allocate(32'd1, 4'd0);
      free_block(REL_LATEST);
      allocate(32'd1, 4'd2);
      drain();
      write_reg(CSR_POOL_BYTES, $urandom_range(1, 400));
      random_run(300);

      // fill the stack, overflow it, unwind it completely
      drain();
      write_reg(CSR_POOL_BASE, '0);
      write_reg(CSR_POOL_BYTES, 32'hFFFF_FFFF);
      repeat (MAX_BLOCKS_DEF + 2) allocate($urandom_range(1, 16), ALIGN_W'($urandom_range(0, 3)));
      repeat (MAX_BLOCKS_DEF + 2) free_block(REL_LATEST);
      random_run(250);

      // region shrunk below the current top
      drain();
      repeat (3) allocate(32'd64, 4'd4);
      drain();
      write_reg(CSR_POOL_BYTES, 32'd16);
      allocate(32'd1, 4'd0);
      repeat (3) free_block(REL_LATEST);
      drain();
      write_reg(CSR_POOL_BASE, $urandom);
      write_reg(CSR_POOL_BYTES, $urandom_range(4096, 1 << 20));
      random_run(350);

      drain();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
